// ===== rtl/core/twr_pkg.sv =====
//------------------------------------------------------------------------------
// twr_pkg
// Shared constants and types for the two-way ranging timestamp table.
//------------------------------------------------------------------------------
package twr_pkg;

    localparam int MaxNeighbours = 16;
    localparam int HistDepth     = 3;
    localparam int SlotW         = 4;
    localparam int TsW           = 40;
    localparam int SeqW          = 8;
    localparam int IdW           = 16;
    localparam int CntW          = 5;

    localparam logic [TsW-1:0] MaxExchReset = 40'd1000;

    // tdata widths, fields padded with zeros to whole bytes
    localparam int InDataW = 160;
    localparam int OutDataW = 312;

    typedef enum logic [1:0] {
        CMD_TX   = 2'd0,
        CMD_PING = 2'd1,
        CMD_EVAL = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_TX       = 3'd0,
        K_ABSORBED = 3'd1,
        K_FULL     = 3'd2,
        K_INCOMPL  = 3'd3,
        K_COMPLETE = 3'd4,
        K_EXPIRED  = 3'd5,
        K_EMPTY    = 3'd6
    } t_kind;

    typedef enum logic {
        REG_SELF_ID = 1'b0,
        REG_MAX_EXCH = 1'b1
    } t_reg;

    // one slot: four phases of tx, rx and seq
    typedef struct packed {
        logic [3:0][TsW-1:0]  tx;
        logic [3:0][TsW-1:0]  rx;
        logic [3:0][SeqW-1:0] sq;
    } t_slot;

endpackage

// ===== rtl/core/twr_timestamp_table_top.sv =====
//------------------------------------------------------------------------------
// twr_timestamp_table_top
// Neighbour timestamp table for double-sided two-way ranging.
//------------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* takes one command word (command in tuser): own
//   transmission, received ping or slot evaluation. Master channel m_axis_*
//   returns one result word per command, kind in tuser (an unused command
//   gives none). Config channel i_cfg_* writes self_id (index 0) or
//   max_exchange_ticks (index 1) while the block is idle.
// Flow:
//   A ping searches the table one entry per cycle with a shared id compare,
//   then goes through fetch, history lookup, update and output. An own
//   transmission goes straight to output, an evaluation through an
//   evaluation step first. One word is in flight at a time; the slave side
//   is ready again the cycle after the result is taken.
// Reset:
//   Synchronous active-low reset empties the table and clears the history.
// Stall:
//   While the receiver holds tready low the result stays in the output
//   register and the slave side stays not ready.
//------------------------------------------------------------------------------
module twr_timestamp_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // source_id[15:0], sender_seq[23:16], sender_last_tx[63:24],
    // event_time[103:64], block_for_me[104], block_last_seq[112:105],
    // block_last_rx[152:113], slot[156:153], zero fill above
    input  logic [twr_pkg::InDataW-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // neighbour_id[15:0], slot_used[19:16], seq_out[27:20], poll_tx[67:28],
    // poll_rx[107:68], response_tx[147:108], response_rx[187:148],
    // final_tx[227:188], final_rx[267:228], report_rx[307:268], zero fill above
    output logic [twr_pkg::OutDataW-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [39:0]  i_cfg_data
);
    import twr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_LOOK0  = 7'b0000100,
        S_LOOK1  = 7'b0001000,
        S_APPLY  = 7'b0010000,
        S_EVAL   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [IdW-1:0] r_self_id;
    logic [TsW-1:0] r_max_exch;

    logic [MaxNeighbours-1:0] r_valid;
    logic [MaxNeighbours-1:0][IdW-1:0] r_node;
    t_slot r_tab [MaxNeighbours];
    logic [HistDepth-1:0][SeqW-1:0] r_hseq;
    logic [HistDepth-1:0][TsW-1:0]  r_htx;
    logic [CntW-1:0] r_count;

    // latched command word
    logic [IdW-1:0]  r_src;
    logic [SeqW-1:0] r_sseq;
    logic [TsW-1:0]  r_slast, r_evt, r_brx;
    logic            r_forme;
    logic [SeqW-1:0] r_bseq;
    logic [SlotW-1:0] r_slot;

    logic [CntW-1:0] r_idx;
    logic            r_found;
    logic [SlotW-1:0] r_ent;
    t_slot           r_work;
    logic            r_hit;
    logic [TsW-1:0]  r_hit_tx;

    logic            r_oval;
    logic [OutDataW+2:0] r_odata;

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = r_oval && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_oval;
    assign o_cfg_ready   = (r_state == S_IDLE) && !r_oval;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tuser  = r_odata[2:0];
    assign m_axis_tdata  = r_odata[OutDataW+2:3];

    // shared history compare: oldest matching entry wins
    logic           h_hit;
    logic [TsW-1:0] h_tx;
    always_comb begin
        h_hit = 1'b0;
        h_tx  = '0;
        for (int i = 0; i < HistDepth; i++) begin
            if (r_hseq[i] == r_bseq) begin
                h_hit = 1'b1;
                h_tx  = r_htx[i];
            end
        end
    end

    // pack kind in the low bits, tdata fields above it
    function automatic logic [OutDataW+2:0] pack_out(
        input t_kind k, input logic [IdW-1:0] id, input logic [SlotW-1:0] s,
        input logic [SeqW-1:0] q, input t_slot w);
        logic [OutDataW+2:0] d;
        d = '0;
        d[2:0]     = k;
        d[18:3]    = id;
        d[22:19]   = s;
        d[30:23]   = q;
        d[70:31]   = w.tx[0];
        d[110:71]  = w.rx[0];
        d[150:111] = w.tx[1];
        d[190:151] = w.rx[1];
        d[230:191] = w.tx[2];
        d[270:231] = w.rx[2];
        d[310:271] = w.rx[3];
        return d;
    endfunction

    function automatic t_slot shift_s(input t_slot w);
        t_slot o;
        o = w;
        o.tx[0] = w.tx[2]; o.rx[0] = w.rx[2]; o.sq[0] = w.sq[2];
        o.tx[1] = w.tx[3]; o.rx[1] = w.rx[3]; o.sq[1] = w.sq[3];
        o.tx[2] = '0; o.rx[2] = '0; o.tx[3] = '0; o.rx[3] = '0;
        return o;
    endfunction

    function automatic t_slot clr_s(input t_slot w);
        t_slot o;
        o = w;
        o.tx = '0;
        o.rx = '0;
        return o;
    endfunction

    function automatic t_slot add_resp(input t_slot w, input logic [SeqW-1:0] ss,
        input logic [TsW-1:0] rx, input logic [SeqW-1:0] bs, input logic [TsW-1:0] brx,
        input logic hit, input logic [TsW-1:0] htx);
        t_slot o;
        o = w;
        o.sq[1] = ss;
        o.rx[1] = rx;
        o.tx[0] = htx;
        if (hit) begin
            o.sq[0] = bs;
            o.rx[0] = brx;
        end else begin
            o.rx[0] = '0;
        end
        return o;
    endfunction

    function automatic t_slot add_rep(input t_slot w, input logic [SeqW-1:0] ss,
        input logic [TsW-1:0] rx, input logic [SeqW-1:0] bs, input logic [TsW-1:0] brx,
        input logic hit, input logic [TsW-1:0] htx);
        t_slot o;
        o = w;
        if (w.tx[1] == '0) begin
            o = add_resp(w, ss, rx, bs, brx, hit, htx);
        end else if (hit) begin
            o.tx[2] = htx;
            o.sq[2] = bs;
            o.sq[3] = ss;
            o.rx[2] = brx;
            o.rx[3] = rx;
        end else begin
            o = clr_s(w);
            o.sq[1] = ss;
            o.rx[1] = rx;
        end
        return o;
    endfunction

    // ping update on the working copy
    t_slot          upd;
    logic [SeqW-1:0] prev_seq;
    always_comb begin
        upd = r_work;
        prev_seq = r_sseq - 8'd1;
        if (upd.sq[1] == prev_seq) begin
            upd.tx[1] = r_slast;
        end else if (upd.sq[3] == prev_seq) begin
            upd.tx[3] = r_slast;
        end
        if (r_forme) begin
            if (upd.rx[1] == '0) begin
                upd = add_resp(clr_s(upd), r_sseq, r_evt, r_bseq, r_brx, r_hit, r_hit_tx);
            end else if (upd.rx[3] != '0) begin
                upd = add_rep(shift_s(upd), r_sseq, r_evt, r_bseq, r_brx, r_hit, r_hit_tx);
            end else begin
                upd = add_rep(upd, r_sseq, r_evt, r_bseq, r_brx, r_hit, r_hit_tx);
            end
        end
        if (upd.rx[1] == '0) begin
            upd.sq[1] = r_sseq;
            upd.rx[1] = r_evt;
        end
    end

    // evaluation checks
    logic            incompl;
    logic [TsW-1:0]  span;
    always_comb begin
        incompl = (r_work.tx[0] == '0) || (r_work.rx[0] == '0) || (r_work.tx[1] == '0) ||
                  (r_work.rx[1] == '0) || (r_work.tx[2] == '0) || (r_work.rx[2] == '0) ||
                  (r_work.rx[3] == '0);
        span = r_work.rx[3] - r_work.tx[0];
    end

    logic [SlotW-1:0] idx_s;
    assign idx_s = r_idx[SlotW-1:0];

    // control sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) begin
                case (t_cmd'(s_axis_tuser))
                    CMD_TX:   n_state = S_OUT;
                    CMD_PING: n_state = S_SEARCH;
                    CMD_EVAL: n_state = S_EVAL;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_SEARCH: if (r_found || r_idx >= r_count) n_state = S_LOOK0;
            S_LOOK0:  n_state = S_LOOK1;
            S_LOOK1:  n_state = S_APPLY;
            S_APPLY:  n_state = S_OUT;
            S_EVAL:   n_state = S_OUT;
            S_OUT:    if (!r_oval || out_acc) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_self_id  <= '0;
            r_max_exch <= MaxExchReset;
            r_valid    <= '0;
            r_hseq     <= '0;
            r_htx      <= '0;
            r_count    <= '0;
            r_oval     <= 1'b0;
            r_found    <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state <= n_state;
            // raise the result, drop it once taken
            if (r_state == S_OUT) begin
                r_oval <= 1'b1;
            end else if (out_acc) begin
                r_oval <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_SELF_ID:  r_self_id  <= i_cfg_data[IdW-1:0];
                    REG_MAX_EXCH: r_max_exch <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (in_acc) begin
                        r_src   <= s_axis_tdata[15:0];
                        r_sseq  <= s_axis_tdata[23:16];
                        r_slast <= s_axis_tdata[63:24];
                        r_evt   <= s_axis_tdata[103:64];
                        r_forme <= s_axis_tdata[104];
                        r_bseq  <= s_axis_tdata[112:105];
                        r_brx   <= s_axis_tdata[152:113];
                        r_slot  <= s_axis_tdata[156:153];
                        r_ent   <= s_axis_tdata[156:153];
                        if (t_cmd'(s_axis_tuser) == CMD_TX) begin
                            // advance history, report previous tx time
                            r_work.tx <= '0;
                            r_work.rx <= '0;
                            r_odata <= pack_out(K_TX, '0, '0, r_hseq[0] + 8'd1,
                                '{tx: {120'd0, r_htx[0]}, rx: '0, sq: '0});
                            for (int i = HistDepth-1; i > 0; i--) begin
                                r_hseq[i] <= r_hseq[i-1];
                                r_htx[i]  <= r_htx[i-1];
                            end
                            r_hseq[0] <= r_hseq[0] + 8'd1;
                            r_htx[0]  <= s_axis_tdata[103:64];
                        end
                    end
                end
                // step through the table, one id compare per cycle
                S_SEARCH: begin
                    if (!r_found && r_idx < r_count) begin
                        if (r_valid[idx_s] && r_node[idx_s] == r_src) begin
                            r_found <= 1'b1;
                            r_ent   <= idx_s;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                // fetch or allocate entry
                S_LOOK0: begin
                    if (r_found) begin
                        r_work <= r_tab[r_ent];
                    end else if (r_count < CntW'(MaxNeighbours)) begin
                        r_ent <= r_count[SlotW-1:0];
                        r_work <= '0;
                        r_valid[r_count[SlotW-1:0]] <= 1'b1;
                        r_node[r_count[SlotW-1:0]]  <= r_src;
                        r_count <= r_count + 5'd1;
                        r_found <= 1'b1;
                    end
                end
                S_LOOK1: begin
                    r_hit    <= h_hit;
                    r_hit_tx <= h_tx;
                end
                S_APPLY: begin
                    if (r_found) begin
                        r_tab[r_ent] <= upd;
                        r_odata <= pack_out(K_ABSORBED, r_src, r_ent, '0, upd);
                    end else begin
                        r_odata <= pack_out(K_FULL, r_src, '0, '0, '0);
                    end
                end
                S_EVAL: begin
                    if (!r_valid[r_slot]) begin
                        r_odata <= pack_out(K_EMPTY, '0, r_slot, '0, '0);
                    end else if (incompl) begin
                        r_odata <= pack_out(K_INCOMPL, r_node[r_slot], r_slot, '0, r_work);
                    end else begin
                        r_odata <= pack_out((span > r_max_exch) ? K_EXPIRED : K_COMPLETE,
                            r_node[r_slot], r_slot, '0, r_work);
                        r_tab[r_slot] <= shift_s(r_work);
                    end
                end
                default: ;
            endcase
            // load slot copy for evaluation
            if (r_state == S_IDLE && in_acc && t_cmd'(s_axis_tuser) == CMD_EVAL)
                r_work <= r_tab[s_axis_tdata[156:153]];
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxNeighbours)) else $error("entry count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !m_axis_tready) |=> r_oval) else $error("result dropped");
    a_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= r_count)) else $error("search overran");
`endif

endmodule

// ===== dv/testbench.sv =====
//------------------------------------------------------------------------------
// twr_timestamp_table_top testbench
// Drives command words (own transmissions, pings, slot evaluations, unused
// commands) and config writes with random gaps and back-pressure, predicts
// every result word from a private copy of the neighbour table and checks each result field by field.
//------------------------------------------------------------------------------
module testbench;
    import twr_pkg::*;

    typedef struct {
        t_cmd             cmd;
        logic [15:0]      src;
        logic [7:0]       sseq;
        logic [39:0]      slast;
        logic [39:0]      evt;
        logic             forme;
        logic [7:0]       bseq;
        logic [39:0]      brx;
        logic [3:0]       slot;
    } t_word;

    typedef struct {
        t_kind            kind;
        logic [15:0]      nid;
        logic [3:0]       slot;
        logic [7:0]       seq;
        logic [6:0][39:0] st;
    } t_res;

    class ranging_scoreboard;
        logic [15:0]      self_id;
        logic [39:0]      max_span;
        bit               used [16];
        logic [15:0]      node [16];
        logic [39:0]      txs [16][4];
        logic [39:0]      rxs [16][4];
        logic [7:0]       marks [16][4];
        logic [7:0]       hseq [3];
        logic [39:0]      htx [3];
        int               count;
        t_res             pending [$];
        int               errors;

        function void clear_all();
            foreach (used[i]) used[i] = 0;
            foreach (hseq[i]) begin
                hseq[i] = 0;
                htx[i] = 0;
            end
            count = 0;
            self_id = 0;
            max_span = 40'd1000;
        endfunction

        // oldest matching history entry wins
        function bit find_tx(logic [7:0] s, output logic [39:0] t);
            bit hit;
            hit = 0;
            t = 0;
            for (int i = 0; i < 3; i++) begin
                if (hseq[i] == s) begin
                    t = htx[i];
                    hit = 1;
                end
            end
            return hit;
        endfunction

        function void wipe(int e);
            for (int p = 0; p < 4; p++) begin
                txs[e][p] = 0;
                rxs[e][p] = 0;
            end
        endfunction

        function void shift(int e);
            txs[e][0] = txs[e][2]; rxs[e][0] = rxs[e][2]; marks[e][0] = marks[e][2];
            txs[e][1] = txs[e][3]; rxs[e][1] = rxs[e][3]; marks[e][1] = marks[e][3];
            txs[e][2] = 0; rxs[e][2] = 0; txs[e][3] = 0; rxs[e][3] = 0;
        endfunction

        function void put_response(int e, t_word w);
            logic [39:0] t;
            marks[e][1] = w.sseq;
            rxs[e][1] = w.evt;
            if (find_tx(w.bseq, t)) begin
                txs[e][0] = t;
                marks[e][0] = w.bseq;
                rxs[e][0] = w.brx;
            end else begin
                txs[e][0] = 0;
                rxs[e][0] = 0;
            end
        endfunction

        function void put_report(int e, t_word w);
            logic [39:0] t;
            if (txs[e][1] == 0) begin
                put_response(e, w);
            end else if (find_tx(w.bseq, t)) begin
                txs[e][2] = t;
                marks[e][2] = w.bseq;
                marks[e][3] = w.sseq;
                rxs[e][2] = w.brx;
                rxs[e][3] = w.evt;
            end else begin
                wipe(e);
                marks[e][1] = w.sseq;
                rxs[e][1] = w.evt;
            end
        endfunction

        function void load_stamps(int e, ref t_res r);
            r.st[0] = txs[e][0]; r.st[1] = rxs[e][0];
            r.st[2] = txs[e][1]; r.st[3] = rxs[e][1];
            r.st[4] = txs[e][2]; r.st[5] = rxs[e][2];
            r.st[6] = rxs[e][3];
        endfunction

        // note an accepted command word and queue its result
        function void note_word(t_word w);
            t_res r;
            int e;
            bit found;
            logic [7:0] prev;
            r.kind = K_TX; r.nid = 0; r.slot = 0; r.seq = 0; r.st = '0;
            case (w.cmd)
                CMD_TX: begin
                    r.seq = hseq[0] + 8'd1;
                    r.st[0] = htx[0];
                    for (int i = 2; i > 0; i--) begin
                        htx[i] = htx[i-1];
                        hseq[i] = hseq[i-1];
                    end
                    hseq[0] = r.seq;
                    htx[0] = w.evt;
                end
                CMD_PING: begin
                    found = 0;
                    e = 0;
                    for (int i = 0; i < 16; i++) begin
                        if (!found && used[i] && node[i] == w.src) begin
                            e = i;
                            found = 1;
                        end
                    end
                    r.nid = w.src;
                    if (!found && count >= 16) begin
                        r.kind = K_FULL;
                        pending = {pending, r};
                        return;
                    end
                    if (!found) begin
                        e = count;
                        count++;
                        used[e] = 1;
                        node[e] = w.src;
                        wipe(e);
                        for (int p = 0; p < 4; p++) marks[e][p] = 0;
                    end
                    prev = w.sseq - 8'd1;
                    if (marks[e][1] == prev) txs[e][1] = w.slast;
                    else if (marks[e][3] == prev) txs[e][3] = w.slast;
                    if (w.forme) begin
                        if (rxs[e][1] == 0) begin
                            wipe(e);
                            put_response(e, w);
                        end else if (rxs[e][3] != 0) begin
                            shift(e);
                            put_report(e, w);
                        end else begin
                            put_report(e, w);
                        end
                    end
                    if (rxs[e][1] == 0) begin
                        marks[e][1] = w.sseq;
                        rxs[e][1] = w.evt;
                    end
                    r.kind = K_ABSORBED;
                    r.slot = e[3:0];
                    load_stamps(e, r);
                end
                CMD_EVAL: begin
                    e = w.slot;
                    r.slot = w.slot;
                    if (!used[e]) begin
                        r.kind = K_EMPTY;
                    end else begin
                        r.nid = node[e];
                        load_stamps(e, r);
                        if (txs[e][0] == 0 || rxs[e][0] == 0 || txs[e][1] == 0 ||
                            rxs[e][1] == 0 || txs[e][2] == 0 || rxs[e][2] == 0 ||
                            rxs[e][3] == 0) begin
                            r.kind = K_INCOMPL;
                        end else begin
                            r.kind = ((rxs[e][3] - txs[e][0]) > max_span) ?
                                     K_EXPIRED : K_COMPLETE;
                            shift(e);
                        end
                    end
                end
                default: return;
            endcase
            pending = {pending, r};
        endfunction

        // compare one result word with the oldest prediction
        function void check_result(logic [2:0] k, logic [OutDataW-1:0] d);
            t_res x;
            logic [6:0][39:0] got;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h %h", $time, k, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            got = d[307:28];
            if (k !== x.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, x.kind, k);
                errors++;
            end
            if (d[15:0] !== x.nid) begin
                $display("%0t: neighbour_id exp %h got %h", $time, x.nid, d[15:0]);
                errors++;
            end
            if (d[19:16] !== x.slot) begin
                $display("%0t: slot_used exp %0d got %0d", $time, x.slot, d[19:16]);
                errors++;
            end
            if (d[27:20] !== x.seq) begin
                $display("%0t: seq_out exp %0d got %0d", $time, x.seq, d[27:20]);
                errors++;
            end
            for (int i = 0; i < 7; i++) begin
                if (got[i] !== x.st[i]) begin
                    $display("%0t: stamp %0d exp %h got %h", $time, i, x.st[i], got[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [InDataW-1:0]    s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutDataW-1:0]   m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = 1'b0;
    logic [39:0]           i_cfg_data = '0;

    ranging_scoreboard     table_model;
    bit                    hold_sink = 0;
    logic [7:0]            my_seq = 0;
    logic [15:0]           peers [20];

    twr_timestamp_table_top uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls, long hold-off while requested
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                while (!m_axis_tvalid) @(posedge i_clk);
            end
        end
    end

    // check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_result(m_axis_tuser, m_axis_tdata);
    end

    initial begin
        #200_000_000;
        $display("twr_timestamp_table_top test failed");
        $finish;
    end

    task automatic write_reg(t_reg idx, logic [39:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        table_model.max_span = (idx == REG_MAX_EXCH) ? val : table_model.max_span;
        if (idx == REG_SELF_ID) table_model.self_id = val[15:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(t_word w, bit no_gap = 0);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, w.slot, w.brx, w.bseq, w.forme, w.evt, w.slast,
                         w.sseq, w.src};
        s_axis_tuser <= w.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        table_model.note_word(w);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (table_model.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(0, 255)), $urandom()};
    endfunction

    function automatic t_word blank();
        t_word w;
        w.cmd = CMD_TX; w.src = 0; w.sseq = 0; w.slast = 0; w.evt = 0;
        w.forme = 0; w.bseq = 0; w.brx = 0; w.slot = 0;
        return w;
    endfunction

    // fully random word, every field at random
    function automatic t_word noise();
        t_word w;
        w.cmd = t_cmd'($urandom_range(0, 3));
        w.src = 16'($urandom()); w.sseq = 8'($urandom()); w.slast = rand40();
        w.evt = rand40(); w.forme = 1'($urandom()); w.bseq = 8'($urandom());
        w.brx = rand40(); w.slot = 4'($urandom());
        return w;
    endfunction

    // well-formed exchange step (own transmission, ping from a known peer or evaluation), small time spans
    task automatic exchange_step(logic [39:0] base);
        t_word w;
        int k;
        k = $urandom_range(0, 19);
        w = blank();
        case ($urandom_range(0, 3))
            0: begin
                w.cmd = CMD_TX;
                w.evt = base + $urandom_range(1, 400);
                my_seq++;
            end
            1, 2: begin
                w.cmd = CMD_PING;
                w.src = peers[k];
                w.sseq = 8'($urandom_range(0, 7));
                w.slast = base + $urandom_range(1, 900);
                w.evt = base + $urandom_range(1, 1500);
                w.forme = $urandom_range(0, 4) != 0;
                w.bseq = my_seq - 8'($urandom_range(0, 3));
                w.brx = base + $urandom_range(0, 900);
            end
            default: begin
                w.cmd = CMD_EVAL;
                w.slot = 4'($urandom());
            end
        endcase
        send_word(w);
    endtask

    initial begin
        t_word w;
        logic [39:0] base;
        table_model = new();
        table_model.clear_all();
        table_model.errors = 0;
        foreach (peers[i]) peers[i] = 16'($urandom());
        peers[0] = 16'h0000;
        peers[1] = 16'hFFFF;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty slots, own transmissions, full exchange, extremes
        w = blank(); w.cmd = CMD_EVAL; w.slot = 4'hF; send_word(w);
        w = blank(); w.cmd = CMD_NONE; send_word(w);
        w = blank(); w.cmd = CMD_TX; w.evt = 40'd100; send_word(w);
        my_seq = 1;
        w = blank(); w.cmd = CMD_PING; w.src = 16'hFFFF; w.sseq = 8'd5;
        w.evt = 40'd300; w.forme = 1; w.bseq = 8'd1; w.brx = 40'd150;
        send_word(w);
        w = blank(); w.cmd = CMD_TX; w.evt = 40'd500; send_word(w);
        my_seq = 2;
        w = blank(); w.cmd = CMD_PING; w.src = 16'hFFFF; w.sseq = 8'd6;
        w.slast = 40'd250; w.evt = 40'd700; w.forme = 1; w.bseq = 8'd2;
        w.brx = 40'd560; send_word(w);
        w = blank(); w.cmd = CMD_EVAL; w.slot = 0; send_word(w);
        w = blank(); w.cmd = CMD_EVAL; w.slot = 0; send_word(w);
        w = blank(); w.cmd = CMD_PING; w.src = 16'h0000; w.sseq = 8'hFF;
        w.slast = '1; w.evt = '1; w.forme = 0; w.bseq = 8'hFF; w.brx = '1;
        send_word(w);
        w = blank(); w.cmd = CMD_PING; w.src = 16'h0000; w.sseq = 8'h00;
        w.slast = '1; w.evt = '1; w.forme = 1; w.bseq = 8'h00; w.brx = '1;
        send_word(w);
        w = blank(); w.cmd = CMD_EVAL; w.slot = 1; send_word(w);
        for (int i = 0; i < 3; i++) begin
            w = blank(); w.cmd = CMD_TX; w.evt = '1; send_word(w);
            my_seq++;
        end
        drain();
        write_reg(REG_SELF_ID, 40'hFFFF);
        write_reg(REG_MAX_EXCH, 40'd0);

        // random phases with several spans, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            base = (ph == 3) ? 40'hFF_FFFF_FF00 : rand40() >> 2;
            for (int n = 0; n < 460; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w = noise();
                    send_word(w);
                    if (w.cmd == CMD_TX) my_seq++;
                end else begin
                    exchange_step(base);
                end
                if (n % 60 == 59) base += 40'd2000;
            end
            // long receiver hold-off while words keep coming
            if (ph == 1) begin
                hold_sink = 1;
                fork
                    begin
                        for (int n = 0; n < 6; n++) begin
                            w = blank(); w.cmd = CMD_EVAL; w.slot = 4'($urandom());
                            send_word(w, 1);
                        end
                    end
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_sink = 0;
                    end
                join
            end
            drain();
            case (ph)
                0: write_reg(REG_MAX_EXCH, '1);
                1: write_reg(REG_MAX_EXCH, 40'd1000);
                2: begin
                    write_reg(REG_SELF_ID, 40'd0);
                    write_reg(REG_MAX_EXCH, 40'd700);
                end
                default: ;
            endcase
        end
        drain();
        if (table_model.errors == 0 && table_model.pending.size() == 0) begin
            $display("twr_timestamp_table_top test passed");
        end else begin
            $display("twr_timestamp_table_top test failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/twr_pkg.sv
rtl/core/twr_timestamp_table_top.sv
dv/testbench.sv
